@@ rtl/pfe_pkg.sv @@
`timescale 1ns / 1ps

package pfe_pkg;

    // Default sizing of the value stack
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths of the token and result beats
    localparam int KIND_W   = 3;
    localparam int DIGIT_W  = 4;
    localparam int TOP_W    = 32;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    // Token kinds; 5 to 7 are ignored
    localparam t_kind KIND_DIGIT = 3'd0;
    localparam t_kind KIND_ADD   = 3'd1;
    localparam t_kind KIND_SUB   = 3'd2;
    localparam t_kind KIND_MUL   = 3'd3;
    localparam t_kind KIND_DIV   = 3'd4;

    // Result status codes
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_UNF  = 2'd1;
    localparam t_status ST_OVF  = 2'd2;
    localparam t_status ST_DIV0 = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    in_ready;
        logic    tok_load;
        logic    push;
        logic    rd_left;
        logic    op_fast;
        logic    alu_start;
        logic    alu_commit;
        logic    stat_wr;
        t_status stat_code;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_fast;
        logic is_div;
        logic full;
        logic lt2;
        logic rhs_zero;
        logic alu_done;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/pfe_ifs.sv @@
`timescale 1ns / 1ps

// Token channel
interface pfe_tok_if import pfe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_kind                token_kind;
    logic [DIGIT_W-1:0]   digit_value;
    logic                 end_of_expr;

    modport source (output valid, output token_kind, output digit_value,
                    output end_of_expr, input ready);
    modport sink   (input valid, input token_kind, input digit_value,
                    input end_of_expr, output ready);
endinterface

// Result channel
interface pfe_res_if import pfe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [TOP_W-1:0] top_value;
    logic [DEPTH_W-1:0]   depth_now;
    t_status              status;
    logic                 final_res;

    modport source (output valid, output top_value, output depth_now,
                    output status, output final_res, input ready);
    modport sink   (input valid, input top_value, input depth_now,
                    input status, input final_res, output ready);
endinterface

@@ rtl/pfe_seqalu.sv @@
`timescale 1ns / 1ps

module pfe_seqalu import pfe_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_is_div,
    input  logic [VALUE_WIDTH-1:0] i_lhs,
    input  logic [VALUE_WIDTH-1:0] i_rhs,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_result
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic          r_is_div;
    logic          r_neg;
    logic [VW-1:0] r_acc;
    logic [VW-1:0] r_a;
    logic [VW-1:0] r_b;
    logic [VW:0]   r_rem;

    logic [VW-1:0] w_lhs_mag;
    logic [VW-1:0] w_rhs_mag;
    logic [VW:0]   w_rem_sh;
    logic [VW:0]   w_trial;
    logic [VW-1:0] w_acc_add;

    // Take operand magnitudes for the divide
    assign w_lhs_mag = i_lhs[VW-1] ? (-i_lhs) : i_lhs;
    assign w_rhs_mag = i_rhs[VW-1] ? (-i_rhs) : i_rhs;

    // One restoring divide step and one shift-add multiply step
    assign w_rem_sh  = {r_rem[VW-1:0], r_a[VW-1]};
    assign w_trial   = w_rem_sh - {1'b0, r_b};
    assign w_acc_add = r_b[0] ? (r_acc + r_a) : r_acc;

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_is_div <= i_is_div;
            r_neg    <= i_lhs[VW-1] ^ i_rhs[VW-1];
            r_acc    <= '0;
            r_rem    <= '0;
            if (i_is_div) begin
                r_a <= w_lhs_mag;
                r_b <= w_rhs_mag;
            end else begin
                r_a <= i_lhs;
                r_b <= i_rhs;
            end
        end else if (r_busy) begin
            if (r_is_div) begin
                if (!w_trial[VW]) begin
                    r_rem <= w_trial;
                    r_a   <= {r_a[VW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_a   <= {r_a[VW-2:0], 1'b0};
                end
            end else begin
                r_acc <= w_acc_add;
                r_a   <= {r_a[VW-2:0], 1'b0};
                r_b   <= {1'b0, r_b[VW-1:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_is_div ? (r_neg ? (-r_a) : r_a) : r_acc;

endmodule

@@ rtl/pfe_dpath.sv @@
`timescale 1ns / 1ps

module pfe_dpath import pfe_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  t_kind                    i_kind,
    input  logic [DIGIT_W-1:0]       i_digit,
    input  logic                     i_last,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [TOP_W-1:0]  o_top,
    output logic [DEPTH_W-1:0]       o_depth,
    output t_status                  o_status,
    output logic                     o_final
);

    localparam int VW = VALUE_WIDTH;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Token held for the whole step
    t_kind              r_kind;
    logic [DIGIT_W-1:0] r_digit;
    logic               r_last;

    // Stack: top entry in a register, the rest in memory
    logic [VW-1:0] mem [STACK_DEPTH];
    logic [VW-1:0] r_top;
    logic [VW-1:0] r_left;
    logic [DW-1:0] r_depth;
    t_status       r_status;

    // Output register
    logic                    r_out_valid;
    logic signed [TOP_W-1:0] r_out_top;
    logic [DEPTH_W-1:0]      r_out_depth;
    t_status                 r_out_status;
    logic                    r_out_final;

    logic [DW-1:0]           w_dm1;
    logic [DW-1:0]           w_dm2;
    logic [VW-1:0]           w_fast;
    logic                    w_alu_done;
    logic [VW-1:0]           w_alu_res;
    logic signed [TOP_W-1:0] w_top_now;

    assign w_dm1  = r_depth - DW'(1);
    assign w_dm2  = r_depth - DW'(2);
    assign w_fast = (r_kind == KIND_SUB) ? (r_left - r_top) : (r_left + r_top);

    pfe_seqalu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.alu_start),
        .i_is_div (r_kind == KIND_DIV),
        .i_lhs    (r_left),
        .i_rhs    (r_top),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    // Latch the accepted token
    always_ff @(posedge i_clk) begin
        if (i_cmd.tok_load) begin
            r_kind  <= i_kind;
            r_digit <= i_digit;
            r_last  <= i_last;
        end
    end

    // Spill the old top on a push, fetch the left operand for an operator
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_depth != '0)) begin
            mem[w_dm1[AW-1:0]] <= r_top;
        end
        if (i_cmd.rd_left) begin
            r_left <= mem[w_dm2[AW-1:0]];
        end
    end

    // Update the top entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= VW'(r_digit);
        end else if (i_cmd.op_fast) begin
            r_top <= w_fast;
        end else if (i_cmd.alu_commit) begin
            r_top <= w_alu_res;
        end
    end

    // Track depth; a final token empties the stack once reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.push) begin
            r_depth <= r_depth + DW'(1);
        end else if (i_cmd.op_fast || i_cmd.alu_commit) begin
            r_depth <= w_dm1;
        end else if (i_cmd.out_load && r_last) begin
            r_depth <= '0;
        end
    end

    // Record the step status
    always_ff @(posedge i_clk) begin
        if (i_cmd.tok_load) begin
            r_status <= ST_OK;
        end else if (i_cmd.stat_wr) begin
            r_status <= i_cmd.stat_code;
        end
    end

    assign w_top_now = (r_depth != '0) ? TOP_W'($signed(r_top)) : '0;

    // Hold the result beat until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_top    <= w_top_now;
            r_out_depth  <= DEPTH_W'(r_depth);
            r_out_status <= r_status;
            r_out_final  <= r_last;
        end
    end

    // Report to the controller
    always_comb begin
        o_stat.is_digit = (r_kind == KIND_DIGIT);
        o_stat.is_op    = (r_kind == KIND_ADD) || (r_kind == KIND_SUB)
                       || (r_kind == KIND_MUL) || (r_kind == KIND_DIV);
        o_stat.is_fast  = (r_kind == KIND_ADD) || (r_kind == KIND_SUB);
        o_stat.is_div   = (r_kind == KIND_DIV);
        o_stat.full     = (r_depth == DW'(STACK_DEPTH));
        o_stat.lt2      = (r_depth < DW'(2));
        o_stat.rhs_zero = (r_top == '0);
        o_stat.alu_done = w_alu_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_top       = r_out_top;
    assign o_depth     = r_out_depth;
    assign o_status    = r_out_status;
    assign o_final     = r_out_final;

endmodule

@@ rtl/pfe_ctrl.sv @@
`timescale 1ns / 1ps

module pfe_ctrl import pfe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_tok_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_LOAD   = 5'b00100,
        S_ARITH  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one token through decode, operand fetch, arithmetic and report
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_tok_valid) begin
                    o_cmd.tok_load = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                if (i_stat.is_digit) begin
                    if (i_stat.full) begin
                        o_cmd.stat_wr   = 1'b1;
                        o_cmd.stat_code = ST_OVF;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_stat.is_op) begin
                    if (i_stat.lt2) begin
                        o_cmd.stat_wr   = 1'b1;
                        o_cmd.stat_code = ST_UNF;
                    end else begin
                        o_cmd.rd_left = 1'b1;
                        n_state       = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (i_stat.is_fast) begin
                    o_cmd.op_fast = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_stat.is_div && i_stat.rhs_zero) begin
                    o_cmd.stat_wr   = 1'b1;
                    o_cmd.stat_code = ST_DIV0;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.alu_start = 1'b1;
                    n_state         = S_ARITH;
                end
            end
            S_ARITH: begin
                if (i_stat.alu_done) begin
                    o_cmd.alu_commit = 1'b1;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/postfix_expression_evaluator.sv @@
// Postfix expression evaluator.
// Tokens arrive one beat at a time on i_tok (kind, digit value, end flag); every
// token produces exactly one beat on o_res with the new top of stack (0 when
// empty), the depth, a status code and the final flag.
// A digit pushes its value; an operator pops right then left operand and
// pushes left op right. Underflow, overflow and divide by zero leave the stack
// as it was. After a token flagged as the end of the expression, the stack
// is emptied.
// A digit, an unknown kind or an underflow goes from decode straight to the
// final step; add, subtract and a divide by zero first fetch the left operand;
// multiply and divide then also run the one-bit-per-cycle shift-add /
// restoring divide unit. A token is taken only in the idle state, which is
// entered again once its predecessor's result is registered.
// The result sits in an output register: a stalled receiver holds the beat
// there while the next token is still accepted and worked on; that token
// waits in its final step until the register frees up.
// Reset (synchronous, active low) empties the stack and drops any pending
// result. Stack memory contents are not cleared.
`timescale 1ns / 1ps

module postfix_expression_evaluator import pfe_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pfe_tok_if.sink        i_tok,
    pfe_res_if.source      o_res
);

    t_cmd  w_cmd;
    t_stat w_stat;

    pfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (i_tok.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pfe_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_kind      (i_tok.token_kind),
        .i_digit     (i_tok.digit_value),
        .i_last      (i_tok.end_of_expr),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_top       (o_res.top_value),
        .o_depth     (o_res.depth_now),
        .o_status    (o_res.status),
        .o_final     (o_res.final_res)
    );

    assign i_tok.ready = w_cmd.in_ready;

endmodule

@@ rtl/pfe_chk.sv @@
`timescale 1ns / 1ps

module pfe_chk import pfe_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_tok_valid,
    input logic                    i_tok_ready,
    input logic                    i_res_valid,
    input logic                    i_res_ready,
    input logic signed [TOP_W-1:0] i_res_top,
    input logic [DEPTH_W-1:0]      i_res_depth,
    input t_status                 i_res_status,
    input logic                    i_res_final
);

    // Stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_top)
            && $stable(i_res_depth) && $stable(i_res_status) && $stable(i_res_final))
        else $error("result beat changed while stalled");

    // One token at a time: no accept right after an accept
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_valid && i_tok_ready |=> !i_tok_ready)
        else $error("token accepted while previous still in work");

    // Underflow leaves fewer than two entries
    a_unf_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status == ST_UNF) |-> i_res_depth < DEPTH_W'(2))
        else $error("underflow reported with two or more entries");

    // Overflow only on a full stack
    a_ovf_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status == ST_OVF) |-> i_res_depth == DEPTH_W'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

endmodule

bind postfix_expression_evaluator pfe_chk #(
    .STACK_DEPTH (STACK_DEPTH)
) u_pfe_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_tok_valid  (i_tok.valid),
    .i_tok_ready  (i_tok.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_top    (o_res.top_value),
    .i_res_depth  (o_res.depth_now),
    .i_res_status (o_res.status),
    .i_res_final  (o_res.final_res)
);

@@ sim/tb_postfix_expression_evaluator.sv @@
`timescale 1ns / 1ps

module tb_postfix_expression_evaluator;
    import pfe_pkg::*;

    localparam int STACK_DEPTH   = DEF_STACK_DEPTH;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_PHASES    = 4;
    localparam int MAX_REPORTS   = 40;
    localparam int DIGIT_MAX     = 9;
    localparam int DIGIT_TOP     = 15;

    // Token kinds that the block skips
    localparam t_kind KIND_SPARE_LO = KIND_DIV + 3'd1;
    localparam t_kind KIND_SPARE_HI = 3'd7;

    localparam logic [TOP_W-1:0] MOST_NEG = {1'b1, {(TOP_W-1){1'b0}}};
    localparam logic [TOP_W-1:0] MINUS_ONE = '1;

    typedef struct {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_token;

    typedef struct {
        logic signed [TOP_W-1:0] top;
        logic [DEPTH_W-1:0]      depth;
        t_status                 status;
        logic                    fin;
    } t_stack_view;

    logic i_clk;
    logic i_rst_n;

    pfe_tok_if tok_if ();
    pfe_res_if res_if ();

    postfix_expression_evaluator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_if.sink),
        .o_res   (res_if.source)
    );

    // Token source, model stack and the views it predicts
    t_token      pending_tokens[$];
    t_stack_view predicted_views[$];
    logic [TOP_W-1:0] model_stack[STACK_DEPTH];
    int model_level;

    int tokens_queued;
    int tokens_sent;
    int tokens_taken;
    int views_checked;
    int finals_seen;
    int status_seen[4];
    int wrap_divides;
    int deepest_level;
    int error_count;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d views still pending",
                     cycle_count, predicted_views.size());
            $display("** postfix_expression_evaluator: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // Apply one token to the model stack and queue the view it produces
    task automatic evaluate_token(input t_token tok);
        t_stack_view      view;
        logic [TOP_W-1:0] lhs;
        logic [TOP_W-1:0] rhs;
        logic [TOP_W-1:0] val;
        logic             op_ok;
        longint           quo;
        view.status = ST_OK;
        val = '0;
        if (tok.kind == KIND_DIGIT) begin
            if (model_level >= STACK_DEPTH) begin
                view.status = ST_OVF;
            end else begin
                model_stack[model_level] = TOP_W'(tok.digit);
                model_level++;
            end
        end else if (tok.kind <= KIND_DIV) begin
            if (model_level < 2) begin
                view.status = ST_UNF;
            end else begin
                rhs = model_stack[model_level-1];
                lhs = model_stack[model_level-2];
                op_ok = 1'b1;
                case (tok.kind)
                    KIND_ADD: val = lhs + rhs;
                    KIND_SUB: val = lhs - rhs;
                    KIND_MUL: val = lhs * rhs;
                    default: begin
                        if (rhs == '0) begin
                            op_ok = 1'b0;
                            view.status = ST_DIV0;
                        end else begin
                            // 64-bit quotient keeps the most negative by minus one defined
                            quo = longint'($signed(lhs)) / longint'($signed(rhs));
                            val = quo[TOP_W-1:0];
                            if (lhs == MOST_NEG && rhs == MINUS_ONE)
                                wrap_divides++;
                        end
                    end
                endcase
                if (op_ok) begin
                    model_level--;
                    model_stack[model_level-1] = val;
                end
            end
        end
        if (model_level > deepest_level)
            deepest_level = model_level;
        view.top   = (model_level > 0) ? model_stack[model_level-1] : '0;
        view.depth = DEPTH_W'(model_level);
        view.fin   = tok.last;
        predicted_views.push_back(view);
        if (tok.last)
            model_level = 0;
    endtask

    // Token driver: change on the falling edge, hold until accepted
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tok_if.valid <= 1'b0;
        end else if (!(tok_if.valid && tokens_taken < tokens_sent)) begin
            if (pending_tokens.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                tok_if.valid       <= 1'b1;
                tok_if.token_kind  <= pending_tokens[0].kind;
                tok_if.digit_value <= pending_tokens[0].digit;
                tok_if.end_of_expr <= pending_tokens[0].last;
                void'(pending_tokens.pop_front());
                tokens_sent <= tokens_sent + 1;
            end else begin
                tok_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver back-pressure
    always @(negedge i_clk) begin
        res_if.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: predict on token beats, check on result beats
    always @(posedge i_clk) begin
        t_token      tok;
        t_stack_view want;
        if (i_rst_n) begin
            if (tok_if.valid && tok_if.ready) begin
                tok.kind  = tok_if.token_kind;
                tok.digit = tok_if.digit_value;
                tok.last  = tok_if.end_of_expr;
                evaluate_token(tok);
                tokens_taken <= tokens_taken + 1;
            end
            if (res_if.valid && res_if.ready) begin
                if (predicted_views.size() == 0) begin
                    report_mismatch("result beat with nothing pending",
                                    longint'(res_if.top_value), 0);
                end else begin
                    want = predicted_views.pop_front();
                    if (res_if.top_value !== want.top)
                        report_mismatch("top_value", longint'(res_if.top_value),
                                        longint'(want.top));
                    if (res_if.depth_now !== want.depth)
                        report_mismatch("depth_now", longint'(res_if.depth_now),
                                        longint'(want.depth));
                    if (res_if.status !== want.status)
                        report_mismatch("status", longint'(res_if.status),
                                        longint'(want.status));
                    if (res_if.final_res !== want.fin)
                        report_mismatch("final_res", longint'(res_if.final_res),
                                        longint'(want.fin));
                    status_seen[want.status]++;
                    if (want.fin)
                        finals_seen++;
                    views_checked++;
                end
            end
        end
    end

    task automatic queue_token(input t_kind kind, input int digit, input logic last);
        t_token tok;
        tok.kind  = kind;
        tok.digit = DIGIT_W'(digit);
        tok.last  = last;
        pending_tokens.push_back(tok);
        tokens_queued++;
    endtask

    function automatic int pick_digit();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(DIGIT_MAX + 1, DIGIT_TOP);
        return $urandom_range(0, DIGIT_MAX);
    endfunction

    function automatic t_kind pick_op();
        return t_kind'($urandom_range(KIND_ADD, KIND_DIV));
    endfunction

    // Well-formed expression with the given number of operands
    task automatic queue_expression(input int leaves);
        int left;
        int level;
        left = leaves;
        level = 0;
        while (!(left == 0 && level <= 1)) begin
            if (left > 0 && (level < 2 || $urandom_range(0, 2) != 0)) begin
                queue_token(KIND_DIGIT, pick_digit(), 1'b0);
                left--;
                level++;
            end else begin
                queue_token(pick_op(), $urandom_range(0, DIGIT_TOP), 1'b0);
                level--;
            end
        end
        pending_tokens[pending_tokens.size()-1].last = 1'b1;
    endtask

    // Fill to near or past the top of the stack, fold a little, then end
    task automatic queue_deep_fill();
        int pushes;
        int folds;
        pushes = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
        folds  = $urandom_range(0, 5);
        repeat (pushes) queue_token(KIND_DIGIT, pick_digit(), 1'b0);
        repeat (folds) queue_token(pick_op(), 0, 1'b0);
        queue_token(KIND_DIGIT, pick_digit(), 1'b1);
    endtask

    // Raw tokens: any kind, end marker at random
    task automatic queue_noise(input int count);
        t_kind kind;
        repeat (count) begin
            if ($urandom_range(0, 19) == 0)
                kind = t_kind'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            else
                kind = t_kind'($urandom_range(KIND_DIGIT, KIND_DIV));
            queue_token(kind, $urandom_range(0, DIGIT_TOP), $urandom_range(0, 7) == 0);
        end
    endtask

    // Build 8^10 * 2 (wraps to the most negative value), then divide by minus one
    task automatic queue_wrap_divide();
        queue_token(KIND_DIGIT, 8, 1'b0);
        repeat (9) begin
            queue_token(KIND_DIGIT, 8, 1'b0);
            queue_token(KIND_MUL, 0, 1'b0);
        end
        queue_token(KIND_DIGIT, 2, 1'b0);
        queue_token(KIND_MUL, 0, 1'b0);
        queue_token(KIND_DIGIT, 0, 1'b0);
        queue_token(KIND_DIGIT, 1, 1'b0);
        queue_token(KIND_SUB, 0, 1'b0);
        queue_token(KIND_DIV, 0, 1'b1);
    endtask

    // Stimulus and end of run
    initial begin
        int send_pct[NUM_PHASES];
        int recv_pct[NUM_PHASES];
        int phase_start;
        int pick;
        send_pct = '{0, 73, 0, 32};
        recv_pct = '{0, 0, 73, 32};
        i_rst_n = 1'b0;
        tok_if.valid = 1'b0;
        tok_if.token_kind = KIND_DIGIT;
        tok_if.digit_value = '0;
        tok_if.end_of_expr = 1'b0;
        res_if.ready = 1'b0;
        model_level = 0;
        tokens_queued = 0;
        tokens_sent = 0;
        tokens_taken = 0;
        views_checked = 0;
        finals_seen = 0;
        status_seen = '{0, 0, 0, 0};
        wrap_divides = 0;
        deepest_level = 0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: underflow on empty and on one entry, divide by zero,
        // skipped kinds, digit above nine, end of expression, then empty again
        queue_token(KIND_ADD, 0, 1'b0);
        queue_token(KIND_DIGIT, DIGIT_MAX, 1'b0);
        queue_token(KIND_SUB, 0, 1'b0);
        queue_token(KIND_DIGIT, 0, 1'b0);
        queue_token(KIND_DIV, 0, 1'b0);
        queue_token(KIND_SPARE_LO, DIGIT_MAX, 1'b0);
        queue_token(KIND_SPARE_HI, DIGIT_TOP, 1'b0);
        queue_token(KIND_DIGIT, DIGIT_TOP, 1'b0);
        queue_token(KIND_ADD, 0, 1'b0);
        queue_token(KIND_MUL, 0, 1'b1);
        queue_token(KIND_ADD, 0, 1'b0);
        queue_wrap_divide();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            @(posedge i_clk);
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            phase_start = tokens_queued;
            queue_deep_fill();
            while (tokens_queued - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    queue_expression(($urandom_range(0, 7) == 0) ?
                                     $urandom_range(10, 20) : $urandom_range(1, 9));
                else if (pick < 90)
                    queue_noise($urandom_range(1, 6));
                else if (pick < 95)
                    queue_wrap_divide();
                else
                    queue_deep_fill();
            end
            // Drain the phase before changing the idle pattern
            while (pending_tokens.size() != 0 || tokens_taken != tokens_sent ||
                   predicted_views.size() != 0)
                @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_views.size() != 0)
            report_mismatch("results never delivered", 0,
                            longint'(predicted_views.size()));

        $display("Covered %0d tokens, %0d results (%0d final)",
                 tokens_taken, views_checked, finals_seen);
        $display("ok/underflow/overflow/div0: %0d/%0d/%0d/%0d, deepest stack %0d",
                 status_seen[ST_OK], status_seen[ST_UNF], status_seen[ST_OVF],
                 status_seen[ST_DIV0], deepest_level);
        $display("Wrapping divides %0d, mismatches %0d", wrap_divides, error_count);
        if (error_count == 0) begin
            $display("** postfix_expression_evaluator: PASSED **");
        end else begin
            $display("** postfix_expression_evaluator: FAILED **");
        end
        $finish;
    end

endmodule
